// ===== rtl/integer_array_sorter_macros.svh =====
// Assertion macros used by the checker file of the integer array sorter.
`ifndef INTEGER_ARRAY_SORTER_MACROS_SVH
`define INTEGER_ARRAY_SORTER_MACROS_SVH

// Clocked assertion on clk, switched off while arst_n is low.
`define IAS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion: whenever ante holds, cons holds in the next cycle.
`define IAS_ASSERT_NEXT(label, ante, cons, msg) \
	`IAS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/ias_pkg.sv =====
// Package of the integer array sorter: sizes, payload types and cell control types.
package ias_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               last_res;
		logic               dropped;
	} res_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] value;
	} cell_data_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/ias_cell.sv =====
// One cell of the sorting chain: holds one value and trades it with its neighbors.
module ias_cell
	import ias_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] new_value,
	input  cell_data_t         prev,
	input  logic               prev_greater,
	input  cell_data_t         next,
	output cell_data_t         cur,
	output logic               greater
);

	logic               valid_q;
	logic signed [31:0] value_q;
	logic               take_prev;
	logic               take_new;
	logic               take_next;

	// An empty cell counts as larger than any value.
	assign greater   = !valid_q || (value_q > new_value);
	assign take_prev = ctrl.insert && greater && prev_greater;
	assign take_new  = ctrl.insert && greater && !prev_greater;
	assign take_next = ctrl.shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_prev) begin
			valid_q <= prev.valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_next) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prev) begin
			value_q <= prev.value;
		end else if (take_new) begin
			value_q <= new_value;
		end else if (take_next) begin
			value_q <= next.value;
		end
	end

	assign cur.valid = valid_q;
	assign cur.value = value_q;

endmodule

// ===== rtl/integer_array_sorter.sv =====
// Top level of the integer array sorter: insertion chain, run control and output register.
// The sorter collects a set of signed 32-bit values, one per input transfer, and keeps them
// in ascending order in a chain of DEPTH cells; when the transfer marked last arrives, it
// emits the whole set as a run of results in ascending order, the largest marked last_res.
// While loading, every cell compares the arriving value at once and keeps its entry, takes
// its smaller neighbor's or takes the arriving value, so no sorting pass follows. After the
// last value the chain shifts toward cell zero one entry per cycle while the output
// register can take a result, and the input side stays closed until the final result has
// entered the output register. Values beyond DEPTH in one set are dropped, and every
// result of that run carries dropped set. No clearing pass is needed after reset.
module integer_array_sorter
	import ias_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	typedef enum logic {
		LOAD,
		DRAIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic               overflow_q;
	logic               res_valid_q;
	res_t               res_q;

	logic               item_xfer;
	logic               has_room;
	logic               pop;
	cell_ctrl_t         ctrl;
	cell_data_t         cells   [DEPTH];
	logic               greater [DEPTH];

	// The input side is open only while a set is being loaded.
	assign item_ready = (state_q == LOAD);
	assign item_xfer  = item_valid && item_ready;
	assign has_room   = (count_q < CNT_W'(DEPTH));

	// During a run, the head of the chain moves into the output register whenever that
	// register is empty or its result is being taken in this cycle.
	assign pop = (state_q == DRAIN) && (!res_valid_q || res_ready);

	assign ctrl.insert = item_xfer && has_room;
	assign ctrl.shift  = pop;

	// The chain: cell zero holds the smallest value. Cell zero has no smaller neighbor, and
	// the last cell shifts in an empty entry during a run.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_data_t prev_d;
		cell_data_t next_d;
		logic       prev_gt;

		if (i == 0) begin : g_head
			assign prev_d  = '0;
			assign prev_gt = 1'b0;
		end else begin : g_body
			assign prev_d  = cells[i-1];
			assign prev_gt = greater[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = cells[i+1];
		end

		ias_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.new_value    (item.value),
			.prev         (prev_d),
			.prev_greater (prev_gt),
			.next         (next_d),
			.cur          (cells[i]),
			.greater      (greater[i])
		);
	end

	// Run control and the output register. The set count and the drop flag are cleared
	// when the final result of a run enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LOAD;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (res_ready) begin
						res_valid_q <= 1'b0;
					end
					if (item_xfer) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (item.last) begin
							state_q <= DRAIN;
						end
					end
				end
				DRAIN: begin
					if (pop) begin
						res_valid_q     <= 1'b1;
						res_q.value_res <= cells[0].value;
						res_q.last_res  <= (count_q == CNT_W'(1));
						res_q.dropped   <= overflow_q;
						count_q         <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							overflow_q <= 1'b0;
							state_q    <= LOAD;
						end
					end
				end
				default: begin
					state_q <= LOAD;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/ias_checker.sv =====
// Port checker of the integer array sorter and its bind to the top level.
`include "integer_array_sorter_macros.svh"

module ias_checker
	import ias_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  item_valid,
	input logic  item_ready,
	input item_t item,
	input logic  res_valid,
	input logic  res_ready,
	input res_t  res
);

	logic res_xfer;
	logic item_xfer;

	assign res_xfer  = res_valid && res_ready;
	assign item_xfer = item_valid && item_ready;

	// A stalled result holds.
	`IAS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

	// The last transfer of a set closes the input side from the next cycle on.
	`IAS_ASSERT_NEXT(a_last_closes, item_xfer && item.last, !item_ready, "input open right after last transfer")

	// Inside a run the next result follows at once with the same drop flag.
	`IAS_ASSERT_NEXT(a_run_flag, res_xfer && !res.last_res, res_valid && (res.dropped == $past(res.dropped)), "run broken or drop flag changed")

	// Results of a run come in ascending order.
	`IAS_ASSERT_NEXT(a_run_order, res_xfer && !res.last_res, res.value_res >= $past(res.value_res), "run not ascending")

endmodule

bind integer_array_sorter ias_checker u_ias_checker (.*);
